// ===== design/fre_pkg.sv =====
package fre_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic [39:0] seq_count;
    logic [39:0] residue_count;
    logic [1:0]  end_status;
    logic        out_last;
  } out_t;

  localparam logic [1:0] KIND_IDENT = 2'd0;
  localparam logic [1:0] KIND_RES   = 2'd1;
  localparam logic [1:0] KIND_SEP   = 2'd2;
  localparam logic [1:0] KIND_SUM   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_HEADER = 2'd1;
  localparam logic [1:0] ST_IN_HEADER = 2'd2;

  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam int QDEPTH = 4;

  // One classified byte: an optional character result and an optional summary.
  typedef struct packed {
    logic       has_char;
    logic       has_sum;
    logic [7:0] ch;
    logic [1:0] kind;
    logic [1:0] status;
  } evt_t;

endpackage

// ===== design/fre_front.sv =====
module fre_front #(
  parameter int MAX_ID_LEN = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_data,
  input  logic         acc,
  input  fre_pkg::in_t in_data,
  output logic         ev_push,
  output fre_pkg::evt_t ev
);
  import fre_pkg::*;

  typedef enum logic [2:0] {
    M_START, M_SEEK, M_SKIPSP, M_IDENT, M_SKIPLINE, M_BODY, M_SKIPHDR
  } mode_t;

  localparam logic [6:0] MaxLen = 7'(MAX_ID_LEN);

  mode_t      mode_r, mode_nxt, cur, parsed;
  logic [6:0] len_r, len_nxt;
  logic       start_hdr_r;
  logic [7:0] c, up;

  always_comb begin
    c   = in_data.in_byte;
    up  = (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_OFS : c;
    cur = mode_r;
    if (mode_r == M_START) begin
      cur = start_hdr_r ? M_SKIPSP : M_SEEK;
    end
    parsed  = cur;
    len_nxt = len_r;
    ev      = '0;
    unique case (cur)
      M_SEEK: begin
        if (c == CH_GT) parsed = M_SKIPSP;
      end
      M_SKIPSP, M_IDENT: begin
        if (cur == M_SKIPSP && c == CH_SPACE) begin
          parsed = cur;
        end else if (c == CH_NL) begin
          parsed = M_BODY;
        end else if (c == CH_SPACE || len_r >= MaxLen) begin
          parsed = M_SKIPLINE;
        end else begin
          ev.has_char = 1'b1;
          ev.ch       = c;
          ev.kind     = KIND_IDENT;
          len_nxt     = len_r + 7'd1;
          parsed      = M_IDENT;
        end
      end
      M_SKIPLINE, M_SKIPHDR: begin
        if (c == CH_NL) parsed = M_BODY;
      end
      M_BODY: begin
        if (up == CH_GT) begin
          ev.has_char = 1'b1;
          ev.ch       = CH_STAR;
          ev.kind     = KIND_SEP;
          parsed      = M_SKIPHDR;
        end else if ((up >= CH_UC_A && up <= CH_UC_Z) || up == CH_STAR) begin
          ev.has_char = 1'b1;
          ev.ch       = up;
          ev.kind     = KIND_RES;
        end
      end
      default: parsed = cur;
    endcase
    mode_nxt = parsed;
    if (in_data.in_last) begin
      ev.has_sum = 1'b1;
      if (parsed == M_SEEK) ev.status = ST_NO_HEADER;
      else if (parsed == M_BODY) ev.status = ST_OK;
      else ev.status = ST_IN_HEADER;
      // The summary closes the file; the next byte starts a new one.
      mode_nxt = M_START;
      len_nxt  = '0;
    end
  end

  assign ev_push = acc && (ev.has_char || ev.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_START;
      len_r       <= '0;
      start_hdr_r <= 1'b0;
    end else begin
      if (cfg_we) start_hdr_r <= cfg_data;
      if (acc) begin
        mode_r <= mode_nxt;
        len_r  <= len_nxt;
      end
    end
  end

endmodule

// ===== design/fre_queue.sv =====
module fre_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fre_pkg::evt_t  wdata,
  input  logic           pop,
  output fre_pkg::evt_t  rdata,
  output logic           full,
  output logic           empty
);
  import fre_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  evt_t          mem [QDEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== design/fre_back.sv =====
module fre_back #(
  parameter int COUNT_WIDTH = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fre_pkg::evt_t ev,
  input  logic          ev_empty,
  output logic          ev_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output fre_pkg::out_t out_data
);
  import fre_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [COUNT_WIDTH-1:0] sep_r, sep_nxt, body_r, body_nxt, seq_sat;
  logic                   sum_phase_r, sum_phase_nxt;
  logic                   valid_r, valid_nxt;
  out_t                   out_r, out_nxt;
  logic                   load_ok, take, emit_sum;
  logic [63:0]            seq_wide, body_wide;

  always_comb begin
    load_ok       = !valid_r || out_pop;
    take          = load_ok && !ev_empty;
    emit_sum      = sum_phase_r || !ev.has_char;
    seq_sat       = (sep_r == CountMax) ? sep_r : sep_r + 1'b1;
    seq_wide      = 64'(seq_sat);
    body_wide     = 64'(body_r);
    sep_nxt       = sep_r;
    body_nxt      = body_r;
    sum_phase_nxt = sum_phase_r;
    valid_nxt     = load_ok ? !ev_empty : valid_r;
    out_nxt       = out_r;
    ev_pop        = 1'b0;
    if (take) begin
      out_nxt = '0;
      if (!emit_sum) begin
        out_nxt.out_byte = ev.ch;
        out_nxt.out_kind = ev.kind;
        if (ev.kind == KIND_SEP) begin
          if (sep_r != CountMax) sep_nxt = sep_r + 1'b1;
        end else if (ev.kind == KIND_RES) begin
          if (body_r != CountMax) body_nxt = body_r + 1'b1;
        end
        // A last byte that also yields a character needs a second beat.
        if (ev.has_sum) sum_phase_nxt = 1'b1;
        else ev_pop = 1'b1;
      end else begin
        out_nxt.out_kind      = KIND_SUM;
        out_nxt.seq_count     = seq_wide[39:0];
        out_nxt.residue_count = body_wide[39:0];
        out_nxt.end_status    = ev.status;
        out_nxt.out_last      = 1'b1;
        sep_nxt               = '0;
        body_nxt              = '0;
        sum_phase_nxt         = 1'b0;
        ev_pop                = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= '0;
      body_r      <= '0;
      sum_phase_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      sep_r       <= sep_nxt;
      body_r      <= body_nxt;
      sum_phase_r <= sum_phase_nxt;
      valid_r     <= valid_nxt;
    end
  end

  assign out_empty = !valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/fasta_residue_extractor.sv =====
// Channel  Ports                              Beat moves when
// input    in_data, in_push, in_full          in_push && !in_full
// result   out_data, out_empty, out_pop       out_pop && !out_empty
// config   cfg_we, cfg_data                   cfg_we
//
// One byte can be accepted every cycle while in_full is low. The parser is combinational,
// so an event is queued at its byte's accepting edge and is then loaded from the queue
// into the result register once that register is free or being popped.
// A final byte that also yields a character gives a character result and then a summary
// result. in_full rises when the four-entry event queue fills, either while out_pop
// is held low or over a run of such final bytes. Reset is synchronous.
module fasta_residue_extractor #(
  parameter int MAX_ID_LEN  = 64,
  parameter int COUNT_WIDTH = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_data,
  input  fre_pkg::in_t  in_data,
  input  logic          in_push,
  output logic          in_full,
  output fre_pkg::out_t out_data,
  output logic          out_empty,
  input  logic          out_pop
);
  import fre_pkg::*;

  logic acc, q_push, q_pop, q_empty;
  evt_t q_wdata, q_rdata;

  assign acc = in_push && !in_full;

  fre_front #(.MAX_ID_LEN(MAX_ID_LEN)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_data, .acc, .in_data,
    .ev_push(q_push), .ev(q_wdata)
  );

  fre_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(in_full), .empty(q_empty)
  );

  fre_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk, .rst_n, .ev(q_rdata), .ev_empty(q_empty), .ev_pop(q_pop),
    .out_pop, .out_empty, .out_data
  );

  // Non-summary results carry no counts or status.
  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.out_kind != KIND_SUM) |->
      (out_data.seq_count == '0 && out_data.residue_count == '0 &&
       out_data.end_status == ST_OK && !out_data.out_last))
    else $error("non-summary result carries summary fields");

  // The summary has a zero byte, a legal status and at least one sequence.
  a_sum_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.out_kind == KIND_SUM) |->
      (out_data.out_byte == 8'd0 && out_data.out_last &&
       out_data.end_status != 2'd3 && out_data.seq_count != '0))
    else $error("malformed summary");

  // Only events that produce output enter the queue.
  a_push_useful: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.has_char || q_wdata.has_sum))
    else $error("empty event pushed");

  // A pushed event never lands while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> acc)
    else $error("event pushed without an accepted byte");

endmodule
